>>> rtl/core/tql_pkg.sv
// Package of the tabular Q-learning agent: fixed widths, register indexes,
// controller states and the command and status bundles between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package tql_pkg;

    // Fixed field widths.
    localparam int STATE_W     = 8;
    localparam int ACT_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int FACTOR_W    = 17;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;

    localparam logic [FACTOR_W-1:0] LEARNING_RATE_RST     = 17'd52429;
    localparam logic [FACTOR_W-1:0] DISCOUNT_RST          = 17'd64881;
    localparam logic [FACTOR_W-1:0] EXPLORE_THRESHOLD_RST = 17'd0;

    // One in Q1.16.
    localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;

    // Input item kinds.
    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_END,
        ST_MUL_G,
        ST_ADD_T,
        ST_MUL_U,
        ST_SUM,
        ST_WRITE,
        ST_FINISH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic load_wr;
        logic scan_rd;
        logic q_rd;
        logic mul_g;
        logic add_t;
        logic mul_u;
        logic sum;
        logic wr_q;
        logic out_load;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic upd;
        logic same_row;
        logic out_free;
    } ctl_sts_t;

endpackage

>>> rtl/core/tql_ctrl.sv
// Controller of the tabular Q-learning agent: sequences clearing, row scan,
// update arithmetic, table writes and result hand-over.
// Depends on tql_pkg for the state type and the command and status bundles.
module tql_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_kind,
    output tql_pkg::ctl_cmd_t cmd,
    input  tql_pkg::ctl_sts_t sts
);
    import tql_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register; reset starts the clearing pass over the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_kind == KIND_LOAD) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                // The last row entry is compared in this cycle.
                if (sts.upd)
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = ST_MUL_G;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_G:
            begin
                cmd.mul_g  = 1'b1;
                state_next = ST_ADD_T;
            end
            ST_ADD_T:
            begin
                cmd.add_t  = 1'b1;
                state_next = ST_MUL_U;
            end
            ST_MUL_U:
            begin
                cmd.mul_u  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // A write into the current row calls for a fresh scan.
                cmd.wr_q   = 1'b1;
                state_next = sts.same_row ? ST_SCAN : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/tql_datapath.sv
// Datapath of the tabular Q-learning agent: configuration registers, Q table
// memory, row argmax, update arithmetic, action choice and output register.
// Depends on tql_pkg; driven by the commands of tql_ctrl.
module tql_datapath #(
    parameter int CANCER_STAGES  = 16,
    parameter int HEALTHY_STAGES = 16,
    parameter int ACTIONS        = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tql_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tql_pkg::FACTOR_W-1:0]         cfg_wr_data,
    input  logic [tql_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [tql_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tuser,
    input  tql_pkg::ctl_cmd_t                    cmd,
    output tql_pkg::ctl_sts_t                    sts
);
    import tql_pkg::*;

    localparam int NUM_STATES = CANCER_STAGES * HEALTHY_STAGES;
    localparam int DEPTH      = NUM_STATES * ACTIONS;
    localparam int AW         = $clog2(DEPTH);
    localparam int AIW        = $clog2(ACTIONS);

    localparam logic [AW-1:0]  ACTIONS_A   = AW'(ACTIONS);
    localparam logic [AW-1:0]  LAST_ADDR   = AW'(DEPTH - 1);
    localparam logic [AIW-1:0] LAST_ACTION = AIW'(ACTIONS - 1);

    localparam logic signed [36:0] SAT_MAX = 37'sh007FFFFFFF;
    localparam logic signed [36:0] SAT_MIN = 37'sh1F80000000;

    // Configuration registers.
    logic [FACTOR_W-1:0] learning_rate_reg;
    logic [FACTOR_W-1:0] discount_reg;
    logic [FACTOR_W-1:0] explore_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg     <= LEARNING_RATE_RST;
            discount_reg          <= DISCOUNT_RST;
            explore_threshold_reg <= EXPLORE_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LEARNING_RATE:     learning_rate_reg     <= cfg_wr_data;
                CFG_DISCOUNT:          discount_reg          <= cfg_wr_data;
                CFG_EXPLORE_THRESHOLD: explore_threshold_reg <= cfg_wr_data;
                default:               ;
            endcase
        end
    end

    // Factors above one act as one.
    logic [FACTOR_W-1:0] alpha;
    logic [FACTOR_W-1:0] one_minus_alpha;
    logic [FACTOR_W-1:0] gamma;

    assign alpha           = (learning_rate_reg > ONE_Q16) ? ONE_Q16 : learning_rate_reg;
    assign one_minus_alpha = ONE_Q16 - alpha;
    assign gamma           = (discount_reg > ONE_Q16) ? ONE_Q16 : discount_reg;

    // Unpacking of the input beat.
    logic [STATE_W-1:0]       in_state;
    logic [STATE_W-1:0]       in_state_c;

    assign in_state   = s_tdata[7:0];
    assign in_state_c = (int'(in_state) >= NUM_STATES) ? STATE_W'(NUM_STATES - 1) : in_state;

    // Latched item.
    logic                     kind_reg;
    logic [STATE_W-1:0]       state_reg;
    logic signed [VALUE_W-1:0] reward_reg;
    logic [FRAC_W-1:0]        rand_frac_reg;
    logic [ACT_W-1:0]         rand_act_reg;
    logic [ACT_W-1:0]         entry_act_reg;
    logic [VALUE_W-1:0]       entry_value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg        <= s_tuser;
            state_reg       <= in_state_c;
            reward_reg      <= s_tdata[40:9];
            rand_frac_reg   <= s_tdata[56:41];
            rand_act_reg    <= s_tdata[59:57];
            entry_act_reg   <= s_tdata[62:60];
            entry_value_reg <= s_tdata[94:63];
        end
    end

    // Pending update of the stored state and action.
    logic upd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            upd_reg <= s_tdata[8] && (s_tuser == KIND_STEP);
        end
        else if (cmd.wr_q)
        begin
            upd_reg <= 1'b0;
        end
    end

    // Stored state and action of the last step.
    logic [STATE_W-1:0] last_state_reg;
    logic [AIW-1:0]     last_action_reg;
    logic [AIW-1:0]     choice;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg  <= '0;
            last_action_reg <= '0;
        end
        else if (cmd.out_load && (kind_reg == KIND_STEP))
        begin
            last_state_reg  <= state_reg;
            last_action_reg <= choice;
        end
    end

    // Clearing pass and row scan counters.
    logic [AW-1:0]  clr_cnt_reg;
    logic [AIW-1:0] scan_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_cnt_reg <= (scan_cnt_reg == LAST_ACTION) ? '0 : scan_cnt_reg + 1'b1;
            end
        end
    end

    // Table addresses.
    logic [AW-1:0] row_base;
    logic [AW-1:0] q_addr;
    logic          col_ok;

    assign row_base = AW'(state_reg) * ACTIONS_A;
    assign q_addr   = AW'(last_state_reg) * ACTIONS_A + AW'(last_action_reg);
    assign col_ok   = int'(entry_act_reg) < ACTIONS;

    // Q table memory: one write and one registered read per cycle.
    logic [VALUE_W-1:0] q_mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;
    logic [VALUE_W-1:0] new_val_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (cmd.clear_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.load_wr && col_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_base + AW'(entry_act_reg);
            mem_wdata = entry_value_reg;
        end
        else if (cmd.wr_q)
        begin
            mem_we    = 1'b1;
            mem_waddr = q_addr;
            mem_wdata = new_val_reg;
        end
    end

    assign mem_re    = cmd.scan_rd || cmd.q_rd;
    assign mem_raddr = cmd.q_rd ? q_addr : row_base + AW'(scan_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            q_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= q_mem[mem_raddr];
        end
    end

    // Row argmax: one entry per cycle, ties keep the lower index.
    logic                      pend_reg;
    logic [AIW-1:0]            pend_idx_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic [AIW-1:0]            best_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            pend_idx_reg <= scan_cnt_reg;
        end
        if (pend_reg && ((pend_idx_reg == '0) || ($signed(rdata_reg) > best_val_reg)))
        begin
            best_val_reg <= rdata_reg;
            best_idx_reg <= pend_idx_reg;
        end
    end

    // Update arithmetic, one multiply step or wide add per stage; the mul_u stage forms both alpha products.
    logic signed [49:0] gm_prod_reg;
    logic signed [49:0] gm_sum;
    logic signed [33:0] target_reg;
    logic signed [51:0] prod_t_reg;
    logic signed [49:0] prod_q_reg;
    logic signed [52:0] upd_sum;
    logic signed [36:0] upd_sh;
    logic [VALUE_W-1:0] upd_sat;

    assign gm_sum  = gm_prod_reg + 50'sd32768;
    assign upd_sum = 53'(prod_t_reg) + 53'(prod_q_reg) + 53'sd32768;
    assign upd_sh  = upd_sum[52:16];

    always_comb
    begin
        if (upd_sh > SAT_MAX)
        begin
            upd_sat = 32'h7FFF_FFFF;
        end
        else if (upd_sh < SAT_MIN)
        begin
            upd_sat = 32'h8000_0000;
        end
        else
        begin
            upd_sat = upd_sh[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_g)
        begin
            gm_prod_reg <= $signed({1'b0, gamma}) * best_val_reg;
        end
        if (cmd.add_t)
        begin
            target_reg <= $signed(gm_sum[49:16]) + 34'(reward_reg);
        end
        if (cmd.mul_u)
        begin
            prod_t_reg <= $signed({1'b0, alpha}) * target_reg;
            prod_q_reg <= $signed({1'b0, one_minus_alpha}) * $signed(rdata_reg);
        end
        if (cmd.sum)
        begin
            new_val_reg <= upd_sat;
        end
    end

    // Epsilon-greedy choice; the random action is reduced below ACTIONS.
    logic explore;
    logic [AIW-1:0] rand_mod;

    always_comb
    begin
        logic [ACT_W-1:0] r;
        r = rand_act_reg;
        for (int i = 0; i < ACT_W; i++)
        begin
            if (int'(r) >= ACTIONS)
            begin
                r = r - ACT_W'(ACTIONS);
            end
        end
        rand_mod = AIW'(r);
    end

    assign explore = {1'b0, rand_frac_reg} < explore_threshold_reg;
    assign choice  = explore ? rand_mod : best_idx_reg;

    // Output register.
    logic             out_valid_reg;
    logic [ACT_W-1:0] out_action_reg;
    logic             out_explored_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_action_reg   <= (kind_reg == KIND_LOAD) ? '0 : ACT_W'(choice);
            out_explored_reg <= (kind_reg == KIND_STEP) && explore;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_action_reg);
    assign m_tuser  = out_explored_reg;

    // Status to the controller.
    assign sts.clear_last = (clr_cnt_reg == LAST_ADDR);
    assign sts.scan_last  = (scan_cnt_reg == LAST_ACTION);
    assign sts.upd        = upd_reg;
    assign sts.same_row   = (last_state_reg == state_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule

>>> rtl/core/tabular_q_learning_agent.sv
// Top level of the tabular Q-learning agent with epsilon-greedy action choice.
// Depends on tql_pkg, tql_ctrl and tql_datapath.
//
//  Channel  Direction  Handshake         Payload
//  s_*      in         tvalid / tready   tuser: kind; tdata: step or load item
//  m_*      out        tvalid / tready   tdata: chosen_action; tuser: explored
//  cfg_*    in         cfg_wr_en only    cfg_index, cfg_wr_data (17 bits)
//
// A step scans the state's row and, with an update, runs the arithmetic stages and the
// table write, then scans the row anew when the updated entry lies in the row just scanned;
// a load writes at most one entry. The single table read port reads one entry per cycle.
// After reset a clearing pass writes zeros over every table entry,
// CANCER_STAGES * HEALTHY_STAGES * ACTIONS of them (1280 by default), with s_tready low.
// A result held in the output register does not stop the next beat from being accepted.
module tabular_q_learning_agent #(
    parameter int CANCER_STAGES  = 16,
    parameter int HEALTHY_STAGES = 16,
    parameter int ACTIONS        = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration.
    input  logic                              cfg_wr_en,
    input  logic [tql_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tql_pkg::FACTOR_W-1:0]      cfg_wr_data,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: state_index[8], has_previous[1], reward[32], random_fraction[16],
    // random_action[3], entry_action[3], entry_value[32], zero pad[1].
    input  logic [tql_pkg::IN_TDATA_W-1:0]    s_tdata,
    // kind.
    input  logic                              s_tuser,
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: chosen_action[3], zero pad[5].
    output logic [tql_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // explored.
    output logic                              m_tuser
);
    import tql_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // Sequencer.
    tql_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_kind  (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Table, arithmetic and output register.
    tql_datapath #(
        .CANCER_STAGES  (CANCER_STAGES),
        .HEALTHY_STAGES (HEALTHY_STAGES),
        .ACTIONS        (ACTIONS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
